@@ design/csps_pkg.sv @@
package csps_pkg;

  localparam int unsigned MAX_DIM        = 4096;
  localparam int unsigned DIST_FRAC_BITS = 8;

  localparam int unsigned CW   = 12;                        // coordinate width
  localparam int unsigned FW_W = 13;                        // frame size register width
  localparam int unsigned SQW  = 2 * CW;                    // squared coordinate width
  localparam int unsigned D2W  = SQW + 1;                   // dx^2 + dy^2
  localparam int unsigned RW   = D2W + 2 * DIST_FRAC_BITS;  // scaled radicand
  localparam int unsigned RB   = (RW + 1) / 2;              // root bits
  localparam int unsigned SVW  = 2 * RB;
  localparam int unsigned LW   = CW + DIST_FRAC_BITS;       // radius limit width
  localparam int unsigned QB   = 8;                         // alpha quotient bits
  localparam int unsigned NW   = LW + QB;                   // gradient numerator width

  localparam int unsigned MODE_OVR  = 0;
  localparam int unsigned MODE_GRAD = 1;
  localparam int unsigned MODE_INV  = 2;

  typedef enum logic [1:0] {
    KIND_RECT    = 2'd0,
    KIND_ELLIPSE = 2'd1,
    KIND_CIRCLE  = 2'd2,
    KIND_SQUARE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_MARGIN = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_SHAPE_KIND   = 3'd2,
    REG_SHAPE_MARGIN = 3'd3,
    REG_BACKGROUND   = 3'd4,
    REG_MODE_FLAGS   = 3'd5,
    REG_OVR_ALPHA    = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [FW_W-1:0] frame_width;
    logic [FW_W-1:0] frame_height;
    kind_e           shape_kind;
    logic [10:0]     shape_margin;
    logic [31:0]     background_argb;
    logic [2:0]      mode_flags;
    logic [7:0]      override_alpha;
  } cfg_t;

  typedef struct packed {
    status_e            status;
    logic [31:0]        argb;
    logic [CW-1:0]      x1;
    logic [CW-1:0]      y1;
    logic [CW-1:0]      x2;
    logic [CW-1:0]      y2;
    logic [CW-1:0]      col;
    logic [CW-1:0]      row;
    logic [CW:0]        w;
    logic [CW:0]        h;
    logic signed [14:0] xs;
    logic signed [14:0] ys;
    kind_e              kind;
    logic signed [14:0] dx;
    logic signed [14:0] dy;
    logic [CW-1:0]      rad;
    logic [CW-1:0]      rx;
    logic [CW-1:0]      ry;
    logic               sq_in;
    logic [SQW-1:0]     dx2;
    logic [SQW-1:0]     dy2;
    logic [SQW-1:0]     rad2;
    logic [SQW-1:0]     rx2;
    logic [SQW-1:0]     ry2;
    logic [2*SQW-1:0]   ex;
    logic [2*SQW-1:0]   ey;
    logic [2*SQW-1:0]   exy;
    logic [D2W-1:0]     d2;
    logic               cin;
    logic               draw;
    logic               use_grad;
    logic [7:0]         alpha;
    logic [SVW-1:0]     sv;
    logic [RB+1:0]      srem;
    logic [RB-1:0]      sroot;
    logic [LW-1:0]      lim;
    logic               g_full;
    logic               g_zero;
    logic [NW-1:0]      drem;
    logic [QB-1:0]      quo;
    logic [7:0]         o_alpha;
    logic [7:0]         o_red;
    logic [7:0]         o_green;
    logic [7:0]         o_blue;
  } pix_t;

endpackage

@@ design/csps_front.sv @@
module csps_front import csps_pkg::*; (
  input  cfg_t          cfg_i,
  input  logic [CW-1:0] cell_left_i,
  input  logic [CW-1:0] cell_top_i,
  input  logic [CW-1:0] cell_right_i,
  input  logic [CW-1:0] cell_bottom_i,
  input  logic [31:0]   cell_argb_i,
  input  logic [CW-1:0] pixel_column_i,
  input  logic [CW-1:0] pixel_row_i,
  output pix_t          pix_o
);

  logic [FW_W-1:0] fw, fh;
  logic            bad;
  logic [CW:0]     w, h;
  logic [14:0]     two_m;
  logic signed [14:0] xs, ys;

  always_comb begin
    fw = (cfg_i.frame_width > FW_W'(MAX_DIM)) ? FW_W'(MAX_DIM) : cfg_i.frame_width;
    fh = (cfg_i.frame_height > FW_W'(MAX_DIM)) ? FW_W'(MAX_DIM) : cfg_i.frame_height;
    bad = ({1'b0, cell_right_i} >= fw) || ({1'b0, cell_bottom_i} >= fh) ||
          (cell_left_i >= cell_right_i) || (cell_top_i >= cell_bottom_i) ||
          (pixel_column_i < cell_left_i) || (pixel_column_i > cell_right_i) ||
          (pixel_row_i < cell_top_i) || (pixel_row_i > cell_bottom_i);
    w = {1'b0, cell_right_i} - {1'b0, cell_left_i} + (CW+1)'(1);
    h = {1'b0, cell_bottom_i} - {1'b0, cell_top_i} + (CW+1)'(1);
    two_m = {3'b0, cfg_i.shape_margin, 1'b0};
    xs = signed'({2'b0, w}) - signed'(two_m);
    ys = signed'({2'b0, h}) - signed'(two_m);

    pix_o = '0;
    pix_o.argb = cell_argb_i;
    pix_o.x1   = cell_left_i;
    pix_o.y1   = cell_top_i;
    pix_o.x2   = cell_right_i;
    pix_o.y2   = cell_bottom_i;
    pix_o.col  = pixel_column_i;
    pix_o.row  = pixel_row_i;
    pix_o.w    = w;
    pix_o.h    = h;
    pix_o.xs   = xs;
    pix_o.ys   = ys;
    if (bad) begin
      pix_o.status = ST_BOUNDS;
    end else if (xs < 15'sd1 || ys < 15'sd1) begin
      pix_o.status = ST_MARGIN;
    end else begin
      pix_o.status = ST_OK;
    end
  end

endmodule

@@ design/cell_shape_pixel_shader_core.sv @@
// Mosaic cell pixel shader: one pixel in, one shaded ARGB pixel plus status out.
// Input channel: in_valid_i / in_stall_o with the cell bounds, cell colour and
// pixel position. Output channel: out_valid_o / out_stall_i with the four colour
// bytes and the status code. Configuration registers are written through
// cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i; the user must
// write them only while idle, as the block itself does not enforce it.
// Throughput is one pixel per clock while out_stall_i stays low. The stages
// are four geometry and multiply stages, one shape decision stage,
// one stage per root bit of the digit-by-digit square root, one scaling stage,
// eight restoring divide stages for the gradient alpha and one output stage.
// Each stage holds its own valid bit and loads when it is empty or its
// successor moves, so bubbles close up while out_stall_i is high and new
// pixels keep entering until the whole pipe is full.
// Reset empties the pipe and returns the registers to their defaults
// (frame 4096 by 4096, override alpha 255, everything else zero).
module cell_shape_pixel_shader_core import csps_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [CW-1:0] cell_left_i,
  input  logic [CW-1:0] cell_top_i,
  input  logic [CW-1:0] cell_right_i,
  input  logic [CW-1:0] cell_bottom_i,
  input  logic [31:0]   cell_argb_i,
  input  logic [CW-1:0] pixel_column_i,
  input  logic [CW-1:0] pixel_row_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_alpha_o,
  output logic [7:0]    out_red_o,
  output logic [7:0]    out_green_o,
  output logic [7:0]    out_blue_o,
  output logic [1:0]    status_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);

  localparam int unsigned S_A2  = 1;
  localparam int unsigned S_B   = 2;
  localparam int unsigned S_C   = 3;
  localparam int unsigned S_D   = 4;
  localparam int unsigned S_SQ0 = 5;
  localparam int unsigned S_G   = S_SQ0 + RB;
  localparam int unsigned S_DV0 = S_G + 1;
  localparam int unsigned S_FIN = S_DV0 + QB;
  localparam int unsigned NS    = S_FIN + 1;
  localparam int unsigned QKW   = $clog2(QB);

  cfg_t cfg_q;
  pix_t front_pix;
  pix_t st_q [NS];
  pix_t nxt  [NS];
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width     <= FW_W'(4096);
      cfg_q.frame_height    <= FW_W'(4096);
      cfg_q.shape_kind      <= KIND_RECT;
      cfg_q.shape_margin    <= '0;
      cfg_q.background_argb <= '0;
      cfg_q.mode_flags      <= '0;
      cfg_q.override_alpha  <= 8'hff;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:  cfg_q.frame_width     <= cfg_data_i[FW_W-1:0];
        REG_FRAME_HEIGHT: cfg_q.frame_height    <= cfg_data_i[FW_W-1:0];
        REG_SHAPE_KIND:   cfg_q.shape_kind      <= kind_e'(cfg_data_i[1:0]);
        REG_SHAPE_MARGIN: cfg_q.shape_margin    <= cfg_data_i[10:0];
        REG_BACKGROUND:   cfg_q.background_argb <= cfg_data_i;
        REG_MODE_FLAGS:   cfg_q.mode_flags      <= cfg_data_i[2:0];
        REG_OVR_ALPHA:    cfg_q.override_alpha  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  csps_front u_front (
    .cfg_i          (cfg_q),
    .cell_left_i    (cell_left_i),
    .cell_top_i     (cell_top_i),
    .cell_right_i   (cell_right_i),
    .cell_bottom_i  (cell_bottom_i),
    .cell_argb_i    (cell_argb_i),
    .pixel_column_i (pixel_column_i),
    .pixel_row_i    (pixel_row_i),
    .pix_o          (front_pix)
  );

  // centre, offsets, radii and the square window
  function automatic pix_t f_geom(pix_t p, cfg_t c);
    pix_t r;
    logic [13:0] cx, cy;
    logic signed [14:0] mn;
    logic [CW:0] hx, hy;
    logic signed [14:0] l, rt, t, b, m;
    r = p;
    cx = {2'b0, p.x1} + {2'b0, p.xs[12:1]};
    cy = {2'b0, p.y1} + {2'b0, p.ys[12:1]};
    r.dx = signed'({3'b0, p.col}) - signed'({1'b0, cx});
    r.dy = signed'({3'b0, p.row}) - signed'({1'b0, cy});
    mn = (p.xs < p.ys) ? p.xs : p.ys;
    r.rad = mn[12:1];
    r.rx = p.w[CW:1];
    r.ry = p.h[CW:1];
    r.kind = c.shape_kind;
    if (p.w == p.h && c.shape_kind == KIND_ELLIPSE) r.kind = KIND_CIRCLE;
    if (p.w == p.h && c.shape_kind == KIND_SQUARE) r.kind = KIND_RECT;
    hx = (p.w > p.h) ? ((p.w - p.h) >> 1) : '0;
    hy = (p.h > p.w) ? ((p.h - p.w) >> 1) : '0;
    m  = signed'({4'b0, c.shape_margin});
    l  = signed'({3'b0, p.x1}) + signed'({2'b0, hx}) + m;
    rt = signed'({3'b0, p.x2}) - signed'({2'b0, hx}) - m;
    t  = signed'({3'b0, p.y1}) + signed'({2'b0, hy}) + m;
    b  = signed'({3'b0, p.y2}) - signed'({2'b0, hy}) - m;
    r.sq_in = (signed'({3'b0, p.col}) >= l) && (signed'({3'b0, p.col}) <= rt) &&
              (signed'({3'b0, p.row}) >= t) && (signed'({3'b0, p.row}) <= b);
    return r;
  endfunction

  function automatic pix_t f_square(pix_t p);
    pix_t r;
    logic signed [29:0] px, py;
    r = p;
    px = p.dx * p.dx;
    py = p.dy * p.dy;
    r.dx2  = px[SQW-1:0];
    r.dy2  = py[SQW-1:0];
    r.rad2 = p.rad * p.rad;
    r.rx2  = p.rx * p.rx;
    r.ry2  = p.ry * p.ry;
    return r;
  endfunction

  function automatic pix_t f_prod(pix_t p);
    pix_t r;
    r = p;
    r.ex  = p.dx2 * p.ry2;
    r.ey  = p.dy2 * p.rx2;
    r.exy = p.rx2 * p.ry2;
    r.d2  = {1'b0, p.dx2} + {1'b0, p.dy2};
    r.cin = r.d2 < {1'b0, p.rad2};
    return r;
  endfunction

  function automatic pix_t f_decide(pix_t p, cfg_t c);
    pix_t r;
    logic [2*SQW:0] sum;
    logic ein, ovr, grad, inv;
    r = p;
    ovr  = c.mode_flags[MODE_OVR];
    grad = c.mode_flags[MODE_GRAD];
    inv  = c.mode_flags[MODE_INV];
    sum = {1'b0, p.ex} + {1'b0, p.ey};
    ein = sum <= {1'b0, p.exy};
    unique case (p.kind)
      KIND_RECT:    r.draw = 1'b1;
      KIND_ELLIPSE: r.draw = ein ^ inv;
      KIND_CIRCLE:  r.draw = p.cin ^ inv;
      KIND_SQUARE:  r.draw = p.sq_in;
      default:      r.draw = 1'b0;
    endcase
    r.alpha = p.argb[31:24];
    r.use_grad = 1'b0;
    if (ovr) begin
      if (!grad) begin
        r.alpha = c.override_alpha;
      end else if (p.kind == KIND_CIRCLE) begin
        r.use_grad = 1'b1;
      end else begin
        r.alpha = c.background_argb[31:24];
      end
    end
    r.sv    = SVW'(p.d2) << (2 * DIST_FRAC_BITS);
    r.srem  = '0;
    r.sroot = '0;
    return r;
  endfunction

  // one root bit per stage
  function automatic pix_t f_sqrt(pix_t p);
    pix_t r;
    logic [RB+3:0] rs, tr;
    r = p;
    rs = {p.srem, p.sv[SVW-1 -: 2]};
    tr = {2'b0, p.sroot, 2'b01};
    if (rs >= tr) begin
      r.srem  = (RB+2)'(rs - tr);
      r.sroot = {p.sroot[RB-2:0], 1'b1};
    end else begin
      r.srem  = rs[RB+1:0];
      r.sroot = {p.sroot[RB-2:0], 1'b0};
    end
    r.sv = p.sv << 2;
    return r;
  endfunction

  function automatic pix_t f_scale(pix_t p, cfg_t c);
    pix_t r;
    logic [RB+LW-1:0] de, le;
    logic [LW-1:0] diff;
    r = p;
    r.lim = LW'(p.rad) << DIST_FRAC_BITS;
    de = (RB+LW)'(p.sroot);
    le = (RB+LW)'(r.lim);
    r.g_full = (p.d2 == '0) || (c.override_alpha == '0);
    r.g_zero = de >= le;
    diff = r.lim - LW'(p.sroot);
    r.drem = r.g_zero ? '0 : NW'(diff) * NW'(c.override_alpha);
    r.quo = '0;
    return r;
  endfunction

  function automatic pix_t f_div(pix_t p, logic [QKW-1:0] k);
    pix_t r;
    logic [NW-1:0] dv;
    r = p;
    dv = NW'(p.lim) << k;
    if (p.drem >= dv) begin
      r.drem = p.drem - dv;
      r.quo[k] = 1'b1;
    end
    return r;
  endfunction

  function automatic pix_t f_finish(pix_t p, cfg_t c);
    pix_t r;
    logic [7:0] a;
    r = p;
    a = p.alpha;
    if (p.use_grad) begin
      if (p.g_full) a = 8'hff;
      else if (p.g_zero) a = 8'h00;
      else a = p.quo;
    end
    if (p.status != ST_OK || !p.draw) begin
      r.o_alpha = c.background_argb[31:24];
      r.o_red   = c.background_argb[23:16];
      r.o_green = c.background_argb[15:8];
      r.o_blue  = c.background_argb[7:0];
    end else begin
      r.o_alpha = a;
      r.o_red   = p.argb[23:16];
      r.o_green = p.argb[15:8];
      r.o_blue  = p.argb[7:0];
    end
    return r;
  endfunction

  // a stage loads when empty or when its successor moves on
  always_comb begin
    en[NS-1] = !v_q[NS-1] || !out_stall_i;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign in_stall_o = !en[0];

  for (genvar s = 0; s < NS; s++) begin : g_st
    pix_t prev;
    logic prev_v;
    if (s == 0) begin : g_first
      assign prev   = front_pix;
      assign prev_v = in_valid_i;
    end else begin : g_next
      assign prev   = st_q[s-1];
      assign prev_v = v_q[s-1];
    end

    always_comb begin
      if (s == 0) begin
        nxt[s] = prev;
      end else if (s == S_A2) begin
        nxt[s] = f_geom(prev, cfg_q);
      end else if (s == S_B) begin
        nxt[s] = f_square(prev);
      end else if (s == S_C) begin
        nxt[s] = f_prod(prev);
      end else if (s == S_D) begin
        nxt[s] = f_decide(prev, cfg_q);
      end else if (s < S_G) begin
        nxt[s] = f_sqrt(prev);
      end else if (s == S_G) begin
        nxt[s] = f_scale(prev, cfg_q);
      end else if (s < S_FIN) begin
        nxt[s] = f_div(prev, QKW'(QB - 1 - (s - S_DV0)));
      end else begin
        nxt[s] = f_finish(prev, cfg_q);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en[s]) begin
        v_q[s] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        st_q[s] <= nxt[s];
      end
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign out_alpha_o = st_q[NS-1].o_alpha;
  assign out_red_o   = st_q[NS-1].o_red;
  assign out_green_o = st_q[NS-1].o_green;
  assign out_blue_o  = st_q[NS-1].o_blue;
  assign status_o    = st_q[NS-1].status;

endmodule

@@ sim/testbench.sv @@
module testbench;
  import csps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 60;
  localparam int ITEMS_PER_PHASE = 128;
  localparam int NUM_PHASES = 12;

  typedef struct packed {
    logic [CW-1:0] left;
    logic [CW-1:0] top;
    logic [CW-1:0] right;
    logic [CW-1:0] bottom;
    logic [31:0]   argb;
    logic [CW-1:0] col;
    logic [CW-1:0] row;
  } cell_item_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    status_e    status;
  } shaded_px_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  cell_item_t cur_item = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] out_alpha_o, out_red_o, out_green_o, out_blue_o;
  logic [1:0] status_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  // shadow copy of the block's registers
  logic [FW_W-1:0] frame_w_q = 13'd4096;
  logic [FW_W-1:0] frame_h_q = 13'd4096;
  kind_e kind_q = KIND_RECT;
  logic [10:0] margin_q = '0;
  logic [31:0] bg_argb_q = '0;
  logic [2:0] flags_q = '0;
  logic [7:0] ovr_alpha_q = 8'd255;

  cell_item_t pending_cells[$];
  shaded_px_t expected_pixels[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_rx = 1'b0;
  int phase_num = 0;
  int errors = 0;

  cell_shape_pixel_shader_core i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .cell_left_i(cur_item.left), .cell_top_i(cur_item.top),
    .cell_right_i(cur_item.right), .cell_bottom_i(cur_item.bottom),
    .cell_argb_i(cur_item.argb), .pixel_column_i(cur_item.col),
    .pixel_row_i(cur_item.row),
    .out_valid_o, .out_stall_i, .out_alpha_o, .out_red_o, .out_green_o,
    .out_blue_o, .status_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic shaded_px_t shade_pixel(cell_item_t c);
    longint x1, y1, x2, y2, cl, rw, fw, fh, w, h, m, xs, ys, cx, cy, rad, dx, dy;
    longint rx, ry, lft, rgt, tp, bt, half;
    longint unsigned d2, root_d, lim;
    kind_e kind;
    bit ovr, grad, inv, draw;
    logic [7:0] bga, a;
    shaded_px_t res;
    x1 = c.left; y1 = c.top; x2 = c.right; y2 = c.bottom;
    cl = c.col; rw = c.row;
    fw = frame_w_q > MAX_DIM ? MAX_DIM : frame_w_q;
    fh = frame_h_q > MAX_DIM ? MAX_DIM : frame_h_q;
    ovr = flags_q[MODE_OVR];
    grad = flags_q[MODE_GRAD];
    inv = flags_q[MODE_INV];
    bga = bg_argb_q[31:24];
    a = c.argb[31:24];
    draw = 1'b0;
    res.alpha = bga;
    res.red = bg_argb_q[23:16];
    res.green = bg_argb_q[15:8];
    res.blue = bg_argb_q[7:0];
    res.status = ST_BOUNDS;
    if (x2 >= fw || y2 >= fh || x1 >= x2 || y1 >= y2 ||
        cl < x1 || cl > x2 || rw < y1 || rw > y2) return res;
    w = x2 - x1 + 1;
    h = y2 - y1 + 1;
    m = margin_q;
    xs = w - 2 * m;
    ys = h - 2 * m;
    res.status = ST_MARGIN;
    if (xs < 1 || ys < 1) return res;
    res.status = ST_OK;
    cx = xs / 2 + x1;
    cy = ys / 2 + y1;
    rad = (xs < ys ? xs : ys) / 2;
    dx = cl - cx;
    dy = rw - cy;
    kind = kind_q;
    // a square cell degenerates ellipse to circle and square to rectangle
    if (w == h && kind == KIND_ELLIPSE) kind = KIND_CIRCLE;
    if (w == h && kind == KIND_SQUARE) kind = KIND_RECT;
    if (kind == KIND_CIRCLE) begin
      d2 = dx * dx + dy * dy;
      draw = (d2 < rad * rad) != inv;
      if (ovr) begin
        if (!grad) begin
          a = ovr_alpha_q;
        end else if (d2 == 0 || ovr_alpha_q == 0) begin
          a = 8'hff;
        end else begin
          root_d = floor_root(d2 << (2 * DIST_FRAC_BITS));
          lim = rad << DIST_FRAC_BITS;
          if (root_d >= lim) a = 8'd0;
          else a = 8'(((lim - root_d) * ovr_alpha_q) / lim);
        end
      end
    end else begin
      if (kind == KIND_RECT) begin
        draw = 1'b1;
      end else if (kind == KIND_ELLIPSE) begin
        rx = w / 2;
        ry = h / 2;
        draw = (dx * dx * ry * ry + dy * dy * rx * rx <= rx * rx * ry * ry) != inv;
      end else begin
        tp = y1; bt = y2; lft = x1; rgt = x2;
        if (h > w) begin
          half = (h - w) / 2;
          tp += half;
          bt -= half;
        end else if (w > h) begin
          half = (w - h) / 2;
          lft += half;
          rgt -= half;
        end
        draw = cl >= lft + m && cl <= rgt - m && rw >= tp + m && rw <= bt - m;
      end
      if (ovr) a = grad ? bga : ovr_alpha_q;
    end
    if (draw) begin
      res.alpha = a;
      res.red = c.argb[23:16];
      res.green = c.argb[15:8];
      res.blue = c.argb[7:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  // driver: payload holds while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) expected_pixels.push_back(shade_pixel(cur_item));
      if (!in_valid_i || !in_stall_o) begin
        if (pending_cells.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item <= pending_cells.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    shaded_px_t exp_px;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          exp_px = expected_pixels.pop_front();
          if (out_alpha_o !== exp_px.alpha)
            report_mismatch($sformatf("alpha %h, want %h", out_alpha_o, exp_px.alpha));
          if (out_red_o !== exp_px.red)
            report_mismatch($sformatf("red %h, want %h", out_red_o, exp_px.red));
          if (out_green_o !== exp_px.green)
            report_mismatch($sformatf("green %h, want %h", out_green_o, exp_px.green));
          if (out_blue_o !== exp_px.blue)
            report_mismatch($sformatf("blue %h, want %h", out_blue_o, exp_px.blue));
          if (status_o !== exp_px.status)
            report_mismatch($sformatf("status %0d, want %0d", status_o, exp_px.status));
        end
      end
      out_stall_i <= hold_rx || ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  frame_w_q = v[12:0];
      REG_FRAME_HEIGHT: frame_h_q = v[12:0];
      REG_SHAPE_KIND:   kind_q = kind_e'(v[1:0]);
      REG_SHAPE_MARGIN: margin_q = v[10:0];
      REG_BACKGROUND:   bg_argb_q = v;
      REG_MODE_FLAGS:   flags_q = v[2:0];
      REG_OVR_ALPHA:    ovr_alpha_q = v[7:0];
      default: ;
    endcase
  endtask

  task automatic push_cell(int l, int t, int r, int b, logic [31:0] argb, int c, int rw);
    cell_item_t it;
    it.left = CW'(l); it.top = CW'(t); it.right = CW'(r); it.bottom = CW'(b);
    it.argb = argb; it.col = CW'(c); it.row = CW'(rw);
    pending_cells.push_back(it);
  endtask

  task automatic push_random_cell();
    int fw, fh, w, h, l, t;
    fw = frame_w_q > MAX_DIM ? MAX_DIM : frame_w_q;
    fh = frame_h_q > MAX_DIM ? MAX_DIM : frame_h_q;
    // mostly in-frame cells with the pixel inside, some noise
    if (fw < 2 || fh < 2 || $urandom_range(99) < 12) begin
      push_cell($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                $urandom_range(4095), $urandom, $urandom_range(4095), $urandom_range(4095));
    end else begin
      if ($urandom_range(99) < 2) begin
        w = $urandom_range(2, fw);
        h = $urandom_range(2, fh);
      end else begin
        w = $urandom_range(2, fw < 48 ? fw : 48);
        h = $urandom_range(2, fh < 48 ? fh : 48);
      end
      if ($urandom_range(99) < 30 && w <= fh) h = w;
      l = $urandom_range(0, fw - w);
      t = $urandom_range(0, fh - h);
      push_cell(l, t, l + w - 1, t + h - 1, $urandom,
                $urandom_range(l, l + w - 1), $urandom_range(t, t + h - 1));
    end
  endtask

  task automatic wait_drained();
    while (pending_cells.size() > 0 || in_valid_i || expected_pixels.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      phase_num = p;
      send_idle_pct = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 1) ? 48 : 35) : 0;
      recv_stall_pct = (p % 4 == 2) ? 48 : (p % 4 == 3) ? 35 : 0;
      if (p > 0) begin
        write_reg(REG_FRAME_WIDTH, p == 3 ? 1 : p == 7 ? 64 : p == 9 ? 4095 : 4096);
        write_reg(REG_FRAME_HEIGHT, p == 3 ? 4096 : p == 7 ? 100 : p == 11 ? 1 : 4096);
        write_reg(REG_SHAPE_KIND, (p + 1) % 4);
        write_reg(REG_SHAPE_MARGIN, p == 1 ? 2 : p == 8 ? 2047 :
                  p == 10 ? $urandom_range(5, 15) : $urandom_range(0, 3));
        write_reg(REG_BACKGROUND, p == 2 ? 32'hffffffff : p == 6 ? 32'h0 : $urandom);
        write_reg(REG_MODE_FLAGS, (p * 3) % 8);
        write_reg(REG_OVR_ALPHA, p == 1 ? 200 : p == 9 ? 0 : p == 2 ? 255 : $urandom_range(255));
      end
      if (p == 1) begin
        // circle with gradient alpha, margin two
        push_cell(0, 0, 4095, 4095, 32'hffffffff, 0, 0);
        push_cell(0, 0, 4095, 4095, 32'h12345678, 2046, 2046);
        push_cell(0, 0, 4095, 4095, 32'h00000000, 4095, 4095);
        push_cell(0, 0, 4095, 4095, 32'haa55aa55, 2046, 1);
        push_cell(5, 0, 5, 10, 32'h11223344, 5, 5);
        push_cell(0, 7, 10, 3, 32'h11223344, 5, 5);
        push_cell(10, 10, 20, 20, 32'h55667788, 9, 15);
        push_cell(10, 10, 20, 20, 32'h55667788, 15, 21);
        push_cell(0, 0, 3, 9, 32'hdeadbeef, 1, 1);
        push_cell(0, 0, 9, 3, 32'hdeadbeef, 1, 1);
        push_cell(0, 0, 4, 4, 32'hcafef00d, 1, 2);
        push_cell(100, 200, 109, 229, 32'h80ff0080, 104, 214);
        push_cell(100, 200, 109, 229, 32'h80ff0080, 101, 203);
        push_cell(4094, 4094, 4095, 4095, 32'h7f7f7f7f, 4095, 4094);
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) push_random_cell();
      wait_drained();
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // long receiver hold while the sender keeps offering
  initial begin
    wait (phase_num == 4);
    repeat (20) @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin
    #3ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
design/csps_pkg.sv
design/csps_front.sv
design/cell_shape_pixel_shader_core.sv
sim/testbench.sv
